### hw/rtl/ffdl_pkg.sv
// ----------------------------------------------------------------------------
// ffdl_pkg
// Shared widths, gain constants and register indexes of the fractional
// feedback delay line.
// ----------------------------------------------------------------------------
package ffdl_pkg;

	localparam int DELAY_W    = 24;
	localparam int FB_W       = 16;
	localparam int CFG_W      = 16;
	localparam int GAIN_REG_W = 17;
	localparam int IDX_W      = 1;

	// q2.14 feedback and q1.15 mix scaling
	localparam int FB_SHIFT  = 14;
	localparam int MIX_SHIFT = 15;

	typedef logic [GAIN_REG_W-1:0] gain_t;
	typedef logic signed [FB_W-1:0] fb_t;
	typedef logic [DELAY_W-1:0] delay_t;
	typedef logic [CFG_W-1:0] cfg_word_t;
	typedef logic [IDX_W-1:0] reg_idx_t;

	localparam gain_t GAIN_ONE = 17'd32768;

	localparam reg_idx_t REG_WET = 1'b0;
	localparam reg_idx_t REG_DRY = 1'b1;

endpackage

### hw/rtl/ffdl_ram.sv
// ----------------------------------------------------------------------------
// ffdl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module ffdl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hw/rtl/fractional_feedback_delay_line_unit.sv
// ----------------------------------------------------------------------------
// fractional_feedback_delay_line_unit
// Audio feedback delay with a fractional, linearly interpolated read tap.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word per sample: sample_in,
// delay_amount (samples, FRACTION_BITS fraction bits) and feedback_gain
// (q2.14). Output channel (out_valid/out_ready) returns one sample_out word
// per input word, in order.
// cfg_wr_en/cfg_index/cfg_data write wet_gain (index 0) and dry_gain
// (index 1), q1.15, clamped to 1.0; write them only while the block is idle.
// After acceptance the delay is first reduced modulo the depth by one
// compare-subtract per cycle, unless STORE_DEPTH is a power of two or the
// integer delay is narrower than the pointer. S_ADDR, S_RD2, S_INT, S_FB and
// S_WR follow, as the store's single read port takes two reads in turn, then
// interpolation, the gain multiplies and the write-back. The result is loaded
// into the output register in S_WR if it is free, after which in_ready
// returns. A stalled receiver holds only that register; the next word is
// still taken and processed, and waits in S_OUT if the register is full.
// After reset the store reads as all zero (entries not yet written since
// reset are masked by a wrap flag and the write pointer), the pointer is 0,
// wet_gain is 1.0 and dry_gain is 0. No clearing pass is needed.
// ----------------------------------------------------------------------------
module fractional_feedback_delay_line_unit #(
	parameter int STORE_DEPTH   = 65536,
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  ffdl_pkg::delay_t           delay_amount,
	input  ffdl_pkg::fb_t              feedback_gain,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	input  logic                       cfg_wr_en,
	input  ffdl_pkg::reg_idx_t         cfg_index,
	input  ffdl_pkg::cfg_word_t        cfg_data
);

	import ffdl_pkg::*;

	localparam int SB        = SAMPLE_BITS;
	localparam int PTR_W     = $clog2(STORE_DEPTH);
	localparam int DINT_W    = DELAY_W - FRACTION_BITS;
	localparam int R_W       = (DINT_W > PTR_W) ? DINT_W : PTR_W;
	localparam bit IS_POW2   = (STORE_DEPTH & (STORE_DEPTH - 1)) == 0;
	localparam int RED_STEPS = IS_POW2 ? 0 : ((DINT_W >= PTR_W) ? DINT_W - PTR_W + 1 : 0);
	localparam int RED_TOP   = (RED_STEPS > 0) ? RED_STEPS - 1 : 0;
	localparam int CNT_W     = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam int IPROD_W   = SB + FRACTION_BITS + 2;
	localparam int FBP_W     = SB + FB_W;
	localparam int MIXP_W    = SB + GAIN_REG_W + 1;
	localparam int SAT_W     = MIXP_W + 1;

	localparam logic [R_W-1:0]   DV_INIT  = R_W'(longint'(STORE_DEPTH) << RED_TOP);
	localparam logic [R_W-1:0]   R_MASK   = IS_POW2 ? R_W'(STORE_DEPTH - 1) : {R_W{1'b1}};
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(STORE_DEPTH - 1);
	localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(STORE_DEPTH);
	localparam logic [CNT_W-1:0] CNT_TOP  = CNT_W'(RED_TOP);
	localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((longint'(1) << (SB - 1)) - 1);
	localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_ADDR = 3'd2;
	localparam logic [2:0] S_RD2  = 3'd3;
	localparam logic [2:0] S_INT  = 3'd4;
	localparam logic [2:0] S_FB   = 3'd5;
	localparam logic [2:0] S_WR   = 3'd6;
	localparam logic [2:0] S_OUT  = 3'd7;

	function automatic logic [SB-1:0] sat_word(input logic signed [SAT_W-1:0] v);
		logic [SB-1:0] res;
		if (v > SAT_HI) begin
			res = SAT_HI[SB-1:0];
		end else if (v < SAT_LO) begin
			res = SAT_LO[SB-1:0];
		end else begin
			res = v[SB-1:0];
		end
		return res;
	endfunction

	// control state
	logic [2:0]       state_q;
	logic [PTR_W-1:0] wp_q;
	logic             wrapped_q;
	logic             out_valid_q;
	gain_t            wet_q;
	gain_t            dry_q;
	logic [CNT_W-1:0] cnt_q;

	// per-word datapath
	logic [R_W-1:0]           r_q;
	logic [R_W-1:0]           dv_q;
	logic [FRACTION_BITS-1:0] dfrac_q;
	logic signed [SB-1:0]     x_q;
	fb_t                      fb_q;
	logic [PTR_W-1:0]         i2_q;
	logic                     ok1_q;
	logic                     ok2_q;
	logic signed [SB-1:0]     a_q;
	logic signed [SB-1:0]     rd_q;
	logic signed [FBP_W-1:0]  fbp_q;
	logic signed [MIXP_W-1:0] wetp_q;
	logic signed [MIXP_W-1:0] dryp_q;
	logic [SB-1:0]            y_q;
	logic [SB-1:0]            out_q;

	// store ports
	logic             ram_wr_en;
	logic [SB-1:0]    ram_wr_data;
	logic             ram_rd_en;
	logic [PTR_W-1:0] ram_rd_addr;
	logic [SB-1:0]    ram_rd_data;

	logic                     in_fire;
	logic                     out_free;
	logic                     out_load;
	logic [PTR_W-1:0]         dmod;
	logic                     borrow;
	logic [PTR_W:0]           idx_diff;
	logic [PTR_W:0]           idx_wrap;
	logic [PTR_W-1:0]         i1;
	logic [PTR_W-1:0]         i2;
	logic [FRACTION_BITS-1:0] frac;
	logic signed [SB-1:0]     b_val;
	logic signed [SB:0]       ab_diff;
	logic signed [IPROD_W-1:0] interp_prod;
	logic signed [SB+1:0]     interp_sum;
	logic signed [FBP_W-1:0]  fb_prod;
	logic signed [MIXP_W-1:0] wet_prod;
	logic signed [MIXP_W-1:0] dry_prod;
	logic signed [SAT_W-1:0]  fb_ext;
	logic signed [SAT_W-1:0]  fb_sum;
	logic signed [SAT_W-1:0]  mix_sum;
	logic [SB-1:0]            y_word;
	logic                     gain_big;
	gain_t                    cfg_gain;

	assign in_ready   = (state_q == S_IDLE);
	assign in_fire    = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign sample_out = out_q;
	assign out_free   = !out_valid_q || out_ready;
	assign out_load   = ((state_q == S_WR) || (state_q == S_OUT)) && out_free;

	// read position: pointer minus integer delay, one more back for a fraction
	assign dmod     = r_q[PTR_W-1:0];
	assign borrow   = |dfrac_q;
	assign idx_diff = {1'b0, wp_q} - {1'b0, dmod} - {{PTR_W{1'b0}}, borrow};
	assign idx_wrap = idx_diff + DEPTH_X;
	assign i1       = idx_diff[PTR_W] ? idx_wrap[PTR_W-1:0] : idx_diff[PTR_W-1:0];
	assign i2       = (i1 == PTR_LAST) ? '0 : i1 + 1'b1;
	// weight of the later entry is 2^F minus the delay fraction
	assign frac     = FRACTION_BITS'(0) - dfrac_q;

	// floor entry plus weighted step toward the next one
	assign b_val       = ok2_q ? $signed(ram_rd_data) : '0;
	assign ab_diff     = $signed({b_val[SB-1], b_val}) - $signed({a_q[SB-1], a_q});
	assign interp_prod = ab_diff * $signed({1'b0, frac});
	assign interp_sum  = $signed({{2{a_q[SB-1]}}, a_q})
		+ interp_prod[IPROD_W-1:FRACTION_BITS];

	assign fb_prod  = rd_q * fb_q;
	assign wet_prod = $signed({1'b0, wet_q}) * rd_q;
	assign dry_prod = $signed({1'b0, dry_q}) * x_q;

	assign fb_ext      = SAT_W'(fbp_q);
	assign fb_sum      = SAT_W'(x_q) + (fb_ext >>> FB_SHIFT);
	assign mix_sum     = SAT_W'(wetp_q) + SAT_W'(dryp_q);
	assign ram_wr_data = sat_word(fb_sum);
	assign y_word      = sat_word(mix_sum >>> MIX_SHIFT);

	assign ram_wr_en   = (state_q == S_WR);
	assign ram_rd_en   = (state_q == S_ADDR) || (state_q == S_RD2);
	assign ram_rd_addr = (state_q == S_ADDR) ? i1 : i2_q;

	assign gain_big = {1'b0, cfg_data} > GAIN_ONE;
	assign cfg_gain = gain_big ? GAIN_ONE : {1'b0, cfg_data};

	ffdl_ram #(
		.WIDTH(SB),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(wp_q),
		.wr_data(ram_wr_data),
		.rd_en  (ram_rd_en),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
			wet_q       <= GAIN_ONE;
			dry_q       <= '0;
			cnt_q       <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_WET: wet_q <= cfg_gain;
					REG_DRY: dry_q <= cfg_gain;
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						cnt_q   <= CNT_TOP;
						state_q <= (RED_STEPS > 0) ? S_RED : S_ADDR;
					end
				end
				S_RED: begin
					if (cnt_q == '0) begin
						state_q <= S_ADDR;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_ADDR: state_q <= S_RD2;
				S_RD2:  state_q <= S_INT;
				S_INT:  state_q <= S_FB;
				S_FB:   state_q <= S_WR;
				S_WR: begin
					wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + 1'b1;
					if (wp_q == PTR_LAST) begin
						wrapped_q <= 1'b1;
					end
					if (out_free) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					r_q     <= R_W'(delay_amount[DELAY_W-1:FRACTION_BITS]) & R_MASK;
					dv_q    <= DV_INIT;
					dfrac_q <= delay_amount[FRACTION_BITS-1:0];
					x_q     <= sample_in;
					fb_q    <= feedback_gain;
				end
			end
			S_RED: begin
				// restoring reduction, one shifted depth per cycle
				if (r_q >= dv_q) begin
					r_q <= r_q - dv_q;
				end
				dv_q <= dv_q >> 1;
			end
			S_ADDR: begin
				i2_q  <= i2;
				ok1_q <= wrapped_q || (i1 < wp_q);
				ok2_q <= wrapped_q || (i2 < wp_q);
			end
			S_RD2: begin
				a_q <= ok1_q ? $signed(ram_rd_data) : '0;
			end
			S_INT: begin
				rd_q <= interp_sum[SB-1:0];
			end
			S_FB: begin
				fbp_q  <= fb_prod;
				wetp_q <= wet_prod;
				dryp_q <= dry_prod;
			end
			S_WR: begin
				y_q <= y_word;
				if (out_free) begin
					out_q <= y_word;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q <= y_q;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// pointer moves by exactly one entry per stored word
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WR) |=> (wp_q == (($past(wp_q) == PTR_LAST) ? '0 : $past(wp_q) + 1'b1)))
		else $error("write pointer did not advance by one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_WR) |=> (wp_q == $past(wp_q)))
		else $error("write pointer moved without a store write");

	// once every entry has been written the masking stays off
	assert property (@(posedge clk) disable iff (!arst_n) !$fell(wrapped_q))
		else $error("wrap flag cleared after being set");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADDR) |-> ({1'b0, dmod} < DEPTH_X)
			&& ((R_W == PTR_W) || (r_q < R_W'(STORE_DEPTH))))
		else $error("delay not reduced below store depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd_en |-> ({1'b0, ram_rd_addr} < DEPTH_X))
		else $error("store read address out of range");
`endif

endmodule

### sim/tb_fractional_feedback_delay_line_unit.sv
// ----------------------------------------------------------------------------
// tb_fractional_feedback_delay_line_unit
// Self-checking bench for the fractional feedback delay line. A clocked
// driver feeds queued sample words under random idling, a clocked monitor
// compares every sample_out with a cycle-free model of the interpolating
// feedback store and the wet/dry mix. The gain registers are changed between
// phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_fractional_feedback_delay_line_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ffdl_pkg::*;

	localparam int SMP_W = 16;
	localparam int FRAC_W = 8;
	localparam int TAIL_CYCLES = 12;

	typedef logic signed [SMP_W-1:0] smp_t;

	typedef struct {
		smp_t   smp;
		delay_t dly;
		fb_t    fb;
	} audio_word_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	smp_t      sample_in = '0;
	delay_t    delay_amount = '0;
	fb_t       feedback_gain = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	smp_t      sample_out;
	logic      cfg_wr_en = 1'b0;
	reg_idx_t  cfg_index = REG_WET;
	cfg_word_t cfg_data = '0;

	fractional_feedback_delay_line_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.delay_amount(delay_amount),
		.feedback_gain(feedback_gain),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// model state
	smp_t        echo_mem [65536] = '{default: '0};
	logic [15:0] echo_wr_ptr = '0;
	longint      wet_level = 32768;
	longint      dry_level = 0;

	audio_word_t pending_words[$];
	smp_t        expected_out_q[$];
	int          words_accepted = 0;
	int          fail_count = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          rx_hold_left = 0;
	logic        sender_hold = 1'b0;

	always #5 clk = ~clk;

	function automatic longint clip_sample(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// one step of the delay line: returns the mixed output, updates the store
	function automatic smp_t delay_line_step(audio_word_t w);
		logic [15:0] tap_lo;
		logic [15:0] tap_hi;
		logic [7:0]  dfrac;
		longint      frac;
		longint      a;
		longint      b;
		longint      rd;
		longint      x;
		longint      fbv;
		longint      wr_val;
		longint      mix;
		dfrac = w.dly[FRAC_W-1:0];
		frac = (dfrac != 0) ? (256 - longint'(dfrac)) : 0;
		tap_lo = echo_wr_ptr - w.dly[23:FRAC_W] - ((dfrac != 0) ? 16'd1 : 16'd0);
		tap_hi = tap_lo + 16'd1;
		a = echo_mem[tap_lo];
		b = echo_mem[tap_hi];
		rd = (a * (256 - frac) + b * frac) >>> FRAC_W;
		x = w.smp;
		fbv = w.fb;
		wr_val = clip_sample(x + ((rd * fbv) >>> FB_SHIFT));
		echo_mem[echo_wr_ptr] = smp_t'(wr_val);
		echo_wr_ptr = echo_wr_ptr + 16'd1;
		mix = wet_level * rd + dry_level * x;
		return smp_t'(clip_sample(mix >>> MIX_SHIFT));
	endfunction

	// driver
	always @(posedge clk) begin
		audio_word_t nxt;
		if (in_valid && in_ready) begin
			nxt.smp = sample_in;
			nxt.dly = delay_amount;
			nxt.fb = feedback_gain;
			expected_out_q.push_back(delay_line_step(nxt));
			words_accepted++;
		end
		if (!in_valid || in_ready) begin
			if (arst_n && !sender_hold && pending_words.size() != 0 &&
			    $urandom_range(0, 99) >= tx_idle_pct) begin
				nxt = pending_words.pop_front();
				in_valid <= 1'b1;
				sample_in <= nxt.smp;
				delay_amount <= nxt.dly;
				feedback_gain <= nxt.fb;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		smp_t want;
		if (out_valid && out_ready) begin
			if (expected_out_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected word, expected none, actual %0d",
				         $time, sample_out);
			end else begin
				want = expected_out_q.pop_front();
				if (sample_out !== want) begin
					fail_count++;
					$display("%0t: sample_out mismatch, expected %0d, actual %0d",
					         $time, want, sample_out);
				end
			end
		end
		if (rx_hold_left > 0) begin
			rx_hold_left <= rx_hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic push_word(smp_t smp, delay_t dly, fb_t fb);
		audio_word_t w;
		w.smp = smp;
		w.dly = dly;
		w.fb = fb;
		pending_words.push_back(w);
	endtask

	task automatic queue_random_words(int n);
		smp_t   smp;
		delay_t dly;
		fb_t    fb;
		int     pick;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 15) begin
				case ($urandom_range(0, 3))
					0: smp = 16'sh7fff;
					1: smp = 16'sh8000;
					2: smp = '0;
					default: smp = '1;
				endcase
			end else begin
				smp = smp_t'($urandom);
			end
			pick = $urandom_range(0, 99);
			// mostly short taps that land on freshly written history
			if (pick < 60)
				dly = {8'h00, 8'($urandom_range(1, 48)), 8'($urandom)};
			else if (pick < 75)
				dly = {14'h0, 2'($urandom), 8'($urandom)};
			else if (pick < 85)
				dly = delay_t'($urandom);
			else if (pick < 95)
				dly = {8'h00, 16'($urandom_range(0, 1100)), 8'($urandom)};
			else begin
				case ($urandom_range(0, 3))
					0: dly = '0;
					1: dly = '1;
					2: dly = 24'hFFFF00;
					default: dly = 24'h0000FF;
				endcase
			end
			if ($urandom_range(0, 99) < 20) begin
				case ($urandom_range(0, 3))
					0: fb = 16'sh8000;
					1: fb = 16'sh7fff;
					2: fb = 16'sh4000;
					default: fb = 16'shC000;
				endcase
			end else begin
				fb = fb_t'($urandom);
			end
			push_word(smp, dly, fb);
		end
	endtask

	task automatic write_gain(reg_idx_t idx, cfg_word_t val);
		longint clamped;
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		clamped = (val > 16'h8000) ? 32768 : longint'(val);
		if (idx == REG_WET)
			wet_level = clamped;
		else
			dry_level = clamped;
	endtask

	// sampled at the falling edge so queue and valid updates have settled
	task automatic wait_idle();
		while (pending_words.size() != 0 || in_valid || expected_out_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset gains: wet only
		tx_idle_pct = 16;
		rx_idle_pct = 50;
		push_word(16'sh7fff, 24'h000000, 16'sh0000);
		push_word(16'sh8000, 24'h000100, 16'sh7fff);
		push_word(16'sh7fff, 24'h000180, 16'sh8000);
		push_word(-16'sd1, 24'h000001, 16'sh0001);
		push_word(16'sd1, 24'h0002FF, -16'sd1);
		push_word(16'sh7fff, 24'hFFFFFF, 16'sh4000);
		push_word(16'sh8000, 24'hFFFF00, 16'shC000);
		push_word(16'sd12345, 24'h010000, 16'sh7fff);
		// drive the feedback into both rails
		for (int i = 0; i < 4; i++)
			push_word(16'sh7fff, 24'h000100, 16'sh7fff);
		for (int i = 0; i < 4; i++)
			push_word(16'sh8000, 24'h000100, 16'sh7fff);
		push_word(16'sh0000, 24'h000380, 16'sh8000);
		push_word(16'sh8000, 24'h000000, 16'sh8000);
		push_word(16'sh7fff, 24'h00017F, 16'sh7fff);
		queue_random_words(300);
		// long receiver stall while the sender keeps offering
		while (words_accepted < 40)
			@(negedge clk);
		rx_hold_left = 400;
		wait_idle();

		write_gain(REG_WET, 16'h0000);
		write_gain(REG_DRY, 16'h8000);
		@(negedge clk);
		queue_random_words(150);
		wait_idle();

		// out-of-range gains clamp to one
		write_gain(REG_WET, 16'hFFFF);
		write_gain(REG_DRY, 16'hFFFF);
		@(negedge clk);
		tx_idle_pct = 50;
		rx_idle_pct = 16;
		for (int i = 0; i < 3; i++)
			push_word(16'sh7fff, 24'h000100, 16'sh7fff);
		for (int i = 0; i < 3; i++)
			push_word(16'sh8000, 24'h000100, 16'sh7fff);
		queue_random_words(170);
		// sender pause until the pipeline has drained
		while (pending_words.size() > 80)
			@(negedge clk);
		sender_hold = 1'b1;
		while (in_valid || expected_out_q.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		sender_hold = 1'b0;
		wait_idle();

		write_gain(REG_WET, cfg_word_t'($urandom_range(0, 32768)));
		write_gain(REG_DRY, cfg_word_t'($urandom_range(0, 32768)));
		@(negedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		queue_random_words(200);
		wait_idle();

		write_gain(REG_WET, 16'h4000);
		write_gain(REG_DRY, 16'h8001);
		@(negedge clk);
		queue_random_words(130);
		wait_idle();
		repeat (TAIL_CYCLES) @(negedge clk);

		if (fail_count == 0 && expected_out_q.size() == 0)
			$display("** fractional_feedback_delay_line_unit: PASSED **");
		else
			$display("** fractional_feedback_delay_line_unit: FAILED **");
		$finish;
	end

	initial begin
		#3ms;
		$display("** fractional_feedback_delay_line_unit: FAILED **");
		$finish;
	end

endmodule

### files.f
hw/rtl/ffdl_pkg.sv
hw/rtl/ffdl_ram.sv
hw/rtl/fractional_feedback_delay_line_unit.sv
sim/tb_fractional_feedback_delay_line_unit.sv
